// ----- sv/m3wsh_pkg.sv -----
package m3wsh_pkg;

	localparam int WORD_W = 32;
	localparam int LEN_W  = 13;
	localparam int OUT_W  = 16;

	localparam logic [WORD_W-1:0] SEED_RESET = 32'd506832829;
	localparam logic [WORD_W-1:0] MIX_C1     = 32'hcc9e2d51;
	localparam logic [WORD_W-1:0] MIX_C2     = 32'h1b873593;
	localparam logic [WORD_W-1:0] MIX_ADD    = 32'he6546b64;
	localparam logic [WORD_W-1:0] FIN_C1     = 32'h85ebca6b;
	localparam logic [WORD_W-1:0] FIN_C2     = 32'hc2b2ae35;

	localparam int BUCKET_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// one classified request between front and back
	typedef struct packed {
		logic [WORD_W-1:0] k;       // premixed word
		logic              present;
		logic              last;
		logic [LEN_W-1:0]  len;
	} q_entry_t;

	function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] v);
		return {v[16:0], v[31:17]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] v);
		return {v[18:0], v[31:19]};
	endfunction

endpackage

// ----- sv/m3wsh_front.sv -----
module m3wsh_front
	import m3wsh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WORD_W-1:0] in_word,
	input  logic              in_present,
	input  logic              in_last,
	input  logic [LEN_W-1:0]  in_len,
	output logic              push,
	output q_entry_t          push_data,
	input  logic              q_full
);

	logic              v_s1;
	logic [WORD_W-1:0] p_s1;
	logic              present_s1;
	logic              last_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              v_s2;
	q_entry_t          ent_s2;
	logic              en1;
	logic              en2;
	logic              keep;

	assign en2      = !v_s2 || !q_full;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign push     = v_s2 && !q_full;
	assign push_data = ent_s2;
	// no word and not last: nothing to do, drop it here
	assign keep     = in_present || in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid && keep;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			p_s1       <= in_word * MIX_C1;
			present_s1 <= in_present;
			last_s1    <= in_last;
			len_s1     <= in_len;
		end
		if (en2 && v_s1) begin
			ent_s2.k       <= rotl15(p_s1) * MIX_C2;
			ent_s2.present <= present_s1;
			ent_s2.last    <= last_s1;
			ent_s2.len     <= len_s1;
		end
	end

endmodule

// ----- sv/m3wsh_queue.sv -----
module m3wsh_queue
	import m3wsh_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output q_entry_t head,
	output logic     empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

// ----- sv/m3wsh_back.sv -----
module m3wsh_back
	import m3wsh_pkg::*;
#(
	parameter int BUCKET_BITS = BUCKET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_wdata,
	input  q_entry_t          head,
	input  logic              q_empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] out_hash,
	output logic [OUT_W-1:0]  out_bucket
);

	localparam logic [WORD_W-1:0] BUCKET_MASK = WORD_W'((64'd1 << BUCKET_BITS) - 64'd1);

	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] run_q;
	logic              in_buf_q;
	logic [WORD_W-1:0] h_cur;
	logic [WORD_W-1:0] h_rot;
	logic [WORD_W-1:0] h_new;
	logic [WORD_W-1:0] fa;
	logic              v_f1;
	logic              v_f2;
	logic              v_f3;
	logic [WORD_W-1:0] a_f1;
	logic [WORD_W-1:0] p_f2;
	logic [WORD_W-1:0] p_f3;
	logic [WORD_W-1:0] b_f2;
	logic              rdy1;
	logic              rdy2;
	logic              rdy3;
	logic              out_free;
	logic              out_v_q;
	logic [WORD_W-1:0] hash_q;

	assign out_free = !out_v_q || out_ready;
	assign rdy3     = !v_f3 || out_free;
	assign rdy2     = !v_f2 || rdy3;
	assign rdy1     = !v_f1 || rdy2;
	assign pop      = !q_empty && (!head.last || rdy1);

	assign h_cur = in_buf_q ? run_q : seed_q;
	assign h_rot = rotl13(h_cur ^ head.k);
	// times five as shift plus add
	assign h_new = head.present ? ({h_rot[WORD_W-3:0], 2'b00} + h_rot + MIX_ADD) : h_cur;
	assign fa    = h_new ^ WORD_W'(head.len);
	assign b_f2  = p_f2 ^ (p_f2 >> 13);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= SEED_RESET;
			in_buf_q <= 1'b0;
			v_f1     <= 1'b0;
			v_f2     <= 1'b0;
			v_f3     <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (pop) begin
				if (head.last) begin
					in_buf_q <= 1'b0;
				end else if (head.present) begin
					in_buf_q <= 1'b1;
				end
			end
			if (rdy1) begin
				v_f1 <= pop && head.last;
			end
			if (rdy2) begin
				v_f2 <= v_f1;
			end
			if (rdy3) begin
				v_f3 <= v_f2;
			end
			if (out_free) begin
				out_v_q <= v_f3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !head.last && head.present) begin
			run_q <= h_new;
		end
		if (rdy1 && pop && head.last) begin
			a_f1 <= fa ^ (fa >> 16);
		end
		if (rdy2 && v_f1) begin
			p_f2 <= a_f1 * FIN_C1;
		end
		if (rdy3 && v_f2) begin
			p_f3 <= b_f2 * FIN_C2;
		end
		if (out_free && v_f3) begin
			hash_q <= p_f3 ^ (p_f3 >> 16);
		end
	end

	assign out_valid  = out_v_q;
	assign out_hash   = hash_q;
	assign out_bucket = OUT_W'(hash_q & BUCKET_MASK);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ready) |=> (out_v_q && $stable(hash_q)))
		else $error("result changed while stalled");
	a_last_room: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |-> rdy1)
		else $error("finalize issued into busy stage");
	a_buf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |=> !in_buf_q)
		else $error("buffer state not cleared after last");

endmodule

// ----- sv/murmur3_word_stream_hash.sv -----
// Streaming MurmurHash3-32 over a buffer delivered as 32-bit little-endian
// words. Each input request carries one word (tuser = 1) or none (tuser = 0);
// tlast marks the end of a buffer and then tdata also carries the buffer
// length in bytes. Words are mixed into a running hash that starts from the
// seed register; on the last request the length is xored in, the fmix32
// finalizer runs and one result (hash plus low BUCKET_BITS bits as a bucket
// index) is sent. Only last requests produce results. Tail bytes beyond whole
// words are not hashed, only counted via the length. Throughput is one input
// request per cycle sustained while results are taken: the front premixes each
// word in a two-stage multiply pipeline, the back updates the running hash
// register as each word is popped (rotate, shift-add, add), and finalization
// is a separate pipeline with the two fmix multiplies in separate stages. With
// an empty queue the last request passes, after the edge that accepted it,
// through the second front stage, the queue write, three finalize stages and
// the output register before the result is valid. The seed is picked up when
// the back starts a buffer, so rewrite it only while no request is in flight;
// a buffer already under way keeps the seed it started with.
module murmur3_word_stream_hash
	import m3wsh_pkg::*;
#(
	parameter int BUCKET_BITS = BUCKET_BITS_DEF,  // 1..16
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // front-to-back queue, >= 2
) (
	input  logic              clk,
	input  logic              arst_n,
	// seed register write
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_wdata,
	// input requests
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [47:0]       s_axis_tdata,  // [31:0] data_word, [44:32] total_bytes
	input  logic              s_axis_tlast,  // is_last
	input  logic              s_axis_tuser,  // word_present
	// results
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [47:0]       m_axis_tdata   // [31:0] hash_value, [47:32] bucket_index
);

	q_entry_t          push_data;
	q_entry_t          head;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	logic [WORD_W-1:0] out_hash;
	logic [OUT_W-1:0]  out_bucket;

	// front: accept, drop empty requests, premix the word
	m3wsh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_word    (s_axis_tdata[31:0]),
		.in_present (s_axis_tuser),
		.in_last    (s_axis_tlast),
		.in_len     (s_axis_tdata[44:32]),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	// decouples front stalls from back stalls
	m3wsh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	// back: running hash, finalizer, output register
	m3wsh_back #(
		.BUCKET_BITS (BUCKET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_hash   (out_hash),
		.out_bucket (out_bucket)
	);

	assign m_axis_tdata = {out_bucket, out_hash};

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

// Streaming murmur3-32 word hash: directed and random buffers against a
// cycle-free predictor, with random gaps on the request side and random
// stalls on the result side.
module tb;
	import m3wsh_pkg::*;

	localparam logic [31:0] RESET_SEED = 32'd506832829;
	localparam logic [31:0] BLK_M1     = 32'hcc9e2d51;
	localparam logic [31:0] BLK_M2     = 32'h1b873593;
	localparam logic [31:0] BLK_ADD    = 32'he6546b64;
	localparam logic [31:0] FMIX_M1    = 32'h85ebca6b;
	localparam logic [31:0] FMIX_M2    = 32'hc2b2ae35;
	localparam int BUCKETS_LOG2   = BUCKET_BITS_DEF;
	localparam int RANDOM_ITEMS   = 400;
	localparam int QUIET_TAIL     = 100;   // last random requests, no gaps or stalls
	localparam int SETTLE_CYCLES  = 20;    // wait after the last result before drain returns
	localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake on either side

	// result word as it sits in m_axis_tdata
	typedef struct packed {
		logic [15:0] bucket;
		logic [31:0] hash;
	} hash_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // [31:0] data_word, [44:32] total_bytes
	logic        s_axis_tlast;   // is_last
	logic        s_axis_tuser;   // word_present
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // [31:0] hash_value, [47:32] bucket_index

	murmur3_word_stream_hash dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// predictor state
	logic [31:0]  seed_now = RESET_SEED;
	logic [31:0]  hash_run = RESET_SEED;
	bit           buf_open = 1'b0;
	hash_result_t pending_hashes[$];

	// idling knobs, percent chance per request / per cycle
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;

	int unsigned n_real     = 0;   // requests that carry a word or end a buffer
	int unsigned n_empty    = 0;
	int unsigned n_words    = 0;
	int unsigned n_buffers  = 0;
	int unsigned n_seeds    = 0;
	int unsigned n_checked  = 0;
	int unsigned n_errors   = 0;
	int unsigned idle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned r);
		return (v << r) | (v >> (32 - r));
	endfunction

	function automatic logic [31:0] mix_block(input logic [31:0] h, input logic [31:0] w);
		logic [31:0] k;
		k = w * BLK_M1;
		k = rotl(k, 15);
		k = k * BLK_M2;
		h = rotl(h ^ k, 13);
		return h * 32'd5 + BLK_ADD;
	endfunction

	function automatic logic [31:0] fmix32(input logic [31:0] h, input logic [12:0] len);
		h = h ^ {19'd0, len};
		h = h ^ (h >> 16);
		h = h * FMIX_M1;
		h = h ^ (h >> 13);
		h = h * FMIX_M2;
		return h ^ (h >> 16);
	endfunction

	// advance the predictor by one accepted request
	task automatic hash_request(input logic [31:0] word, input bit present, input bit last,
			input logic [12:0] len);
		logic [31:0]  h;
		hash_result_t r;
		h = buf_open ? hash_run : seed_now;
		if (present) begin
			h = mix_block(h, word);
			hash_run = h;
			buf_open = 1'b1;
			n_words++;
		end
		if (!present && !last)
			n_empty++;
		else
			n_real++;
		if (last) begin
			r.hash   = fmix32(h, len);
			r.bucket = 16'(64'(r.hash) & ((64'd1 << BUCKETS_LOG2) - 64'd1));
			pending_hashes.push_back(r);
			hash_run = seed_now;
			buf_open = 1'b0;
			n_buffers++;
		end
	endtask

	// entered and left at a falling edge; tvalid stays high for a following request
	task automatic send_request(input logic [31:0] word, input bit present, input bit last,
			input logic [12:0] len);
		int unsigned gap;
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, len, word};
		s_axis_tlast  <= last;
		s_axis_tuser  <= present;
		do @(posedge clk); while (!s_axis_tready);
		hash_request(word, present, last, len);
		@(negedge clk);
	endtask

	// stop sending, wait for every result, then let in-flight words settle
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		seed_now  = value;
		if (!buf_open)
			hash_run = value;
		n_seeds++;
	endtask

	// n_word words, optionally the last one riding on the tlast request
	task automatic run_buffer(input int unsigned n_word, input logic [12:0] len,
			input int unsigned noise_pct);
		bit on_last;
		on_last = (n_word != 0) && ($urandom_range(0, 1) == 1);
		for (int unsigned i = 0; i < n_word - on_last; i++) begin
			while (noise_pct != 0 && $urandom_range(1, 100) <= noise_pct)
				send_request($urandom, 1'b0, 1'b0, 13'($urandom));
			send_request($urandom, 1'b1, 1'b0, 13'($urandom));
		end
		send_request($urandom, on_last, 1'b1, len);
	endtask

	task automatic report(input string what, input hash_result_t want,
			input hash_result_t got);
		n_errors++;
		if (n_errors <= 10)
			$display("%0t: %s: expected hash %h bucket %h, got hash %h bucket %h",
				$realtime, what, want.hash, want.bucket, got.hash, got.bucket);
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		hash_result_t got;
		hash_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_hashes.size() == 0) begin
				report("result with no request pending", '0, got);
			end else begin
				want = pending_hashes.pop_front();
				n_checked++;
				if (got.hash !== want.hash)
					report("hash_value mismatch", want, got);
				else if (got.bucket !== want.bucket)
					report("bucket_index mismatch", want, got);
			end
		end
	end

	// result-side backpressure in random bursts
	initial begin : result_stalls
		int unsigned stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left != 0 && stall_pct != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				stall_left = $urandom_range(1, 16) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// no handshake on either side for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_count <= 0;
		end else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	// empty buffers and a one-word buffer under the reset seed
	task automatic test_reset_seed;
		send_request(32'h0, 1'b0, 1'b1, 13'd0);
		send_request(32'hffffffff, 1'b0, 1'b1, 13'd3);
		send_request(32'h0, 1'b1, 1'b1, 13'd4);
	endtask

	// field extremes, empty requests inside a buffer, odd lengths
	task automatic test_field_extremes;
		send_request(32'hffffffff, 1'b1, 1'b1, 13'h1fff);
		send_request(32'haaaaaaaa, 1'b1, 1'b0, 13'h0aaa);
		send_request(32'hdeadbeef, 1'b0, 1'b0, 13'h1fff);   // ignored
		send_request(32'h55555555, 1'b1, 1'b0, 13'h1555);
		send_request(32'hffffffff, 1'b0, 1'b1, 13'd8);
		send_request(32'h12345678, 1'b1, 1'b1, 13'd4097);   // past the max length
		send_request(32'h80000000, 1'b1, 1'b0, 13'd0);
		send_request(32'h00000001, 1'b1, 1'b0, 13'd0);
		send_request(32'h0, 1'b0, 1'b1, 13'd0);              // length disagrees with words
		send_request(32'h0, 1'b0, 1'b0, 13'd0);
		send_request(32'h0, 1'b0, 1'b1, 13'd4096);
	endtask

	// seed extremes and a random value, each for a short and an empty buffer
	task automatic test_seed_values;
		logic [31:0] seeds [5];
		seeds = '{32'h0, 32'hffffffff, 32'h1, 32'h80000000, $urandom};
		foreach (seeds[i]) begin
			drain();
			write_seed(seeds[i]);
			send_request($urandom, 1'b1, 1'b1, 13'd4);
			send_request($urandom, 1'b0, 1'b1, 13'd2);
		end
	endtask

	// a seed written mid-buffer waits for the next buffer
	task automatic test_seed_mid_buffer;
		drain();
		send_request($urandom, 1'b1, 1'b0, 13'd0);
		drain();
		write_seed($urandom);
		send_request($urandom, 1'b1, 1'b0, 13'd0);
		send_request($urandom, 1'b0, 1'b1, 13'd8);
		send_request($urandom, 1'b0, 1'b1, 13'd1);
		// only empty requests so far: the buffer has not started yet
		send_request($urandom, 1'b0, 1'b0, 13'd0);
		drain();
		write_seed($urandom);
		send_request($urandom, 1'b0, 1'b1, 13'd0);
	endtask

	// more words than the nominal buffer size; nothing may saturate
	task automatic test_overlong_buffer;
		run_buffer(1030, 13'd4096, 0);
	endtask

	task automatic test_random_buffers;
		int unsigned target;
		int unsigned n;
		logic [12:0] len;
		bit quiet;
		target = n_real + RANDOM_ITEMS;
		quiet = 1'b0;
		while (n_real < target) begin
			if (!quiet && n_real + QUIET_TAIL >= target) begin
				quiet = 1'b1;
				gap_pct = 0;
				stall_pct = 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				// new idling mode; zero gives stretches at full rate
				gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
				stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 64) : $urandom_range(0, 10);
			if ($urandom_range(0, 9) == 0)
				len = 13'($urandom);
			else
				len = 13'(4 * n + $urandom_range(0, 3));
			run_buffer(n, len, ($urandom_range(0, 3) == 0) ? 20 : 0);
			if (!quiet && $urandom_range(0, 11) == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: write_seed(32'h0);
					1: write_seed(32'hffffffff);
					default: write_seed($urandom);
				endcase
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		s_axis_tuser  = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		gap_pct = 25;
		stall_pct = 25;
		test_reset_seed();
		test_field_extremes();
		test_seed_values();
		test_seed_mid_buffer();
		test_overlong_buffer();
		test_random_buffers();
		drain();

		$display("%0d buffers, %0d words, %0d empty requests, %0d seed writes",
			n_buffers, n_words, n_empty, n_seeds);
		$display("%0d hashes checked, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0 && pending_hashes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/m3wsh_pkg.sv
sv/m3wsh_front.sv
sv/m3wsh_queue.sv
sv/m3wsh_back.sv
sv/murmur3_word_stream_hash.sv
test/tb.sv
